### rtl/ttcb_pkg.sv
// ----------------------------------------------------------------------------
// ttcb_pkg: text terminal char buffer shared definitions
// Geometry, opcodes, character codes and internal structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcb_pkg;

    localparam int MAX_COLS   = 128;
    localparam int MAX_ROWS   = 64;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 6;
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int DEPTH      = MAX_COLS * MAX_ROWS;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET = 7'd25;
    localparam logic [7:0] COLS_MAX   = 8'd128;
    localparam logic [6:0] ROWS_MAX   = 7'd64;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] CH_LAST_PRT  = 8'd126;

    typedef enum logic [1:0] {
        OP_NOP  = 2'd0,
        OP_KEY  = 2'd1,
        OP_RAW  = 2'd2,
        OP_READ = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLS = 2'd0,
        REG_ROWS = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] act_cols;
        logic [6:0] act_rows;
    } cfg_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

endpackage

`default_nettype wire

### rtl/ttcb_if.sv
// ----------------------------------------------------------------------------
// ttcb_if: channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttcb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [5:0] read_row;
    logic [6:0] read_col;

    modport source (output valid, opcode, char_code, read_row, read_col, input ready);
    modport sink   (input valid, opcode, char_code, read_row, read_col, output ready);
endinterface

interface ttcb_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] cursor_col;
    logic [5:0] cursor_row;
    logic       scrolled;
    logic [7:0] cell_char;

    modport source (output valid, cursor_col, cursor_row, scrolled, cell_char, input ready);
    modport sink   (input valid, cursor_col, cursor_row, scrolled, cell_char, output ready);
endinterface

interface ttcb_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/text_terminal_char_buffer_unit.sv
// Each accepted item passes through EXEC and DONE, and DONE registers the result once
// the output register is free; only then does ready return, with the state back in IDLE.
// A scrolling item walks the store between EXEC and DONE: the sequencer copies one cell
// per read/write state pair through the registered-read cell RAM, then blanks the last row.
// One item at a time; ready is low from acceptance until the item's result is registered.
// Reset: cursor to 0, registers to 80 columns by 25 rows, then a pass over all 8192 cells
// fills the store with spaces while ready stays low.
// ----------------------------------------------------------------------------
// text_terminal_char_buffer_unit: character cell terminal store
// Cursor handling, wrap, scroll and cell readback over a cell RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_char_buffer_unit
    import ttcb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ttcb_cfg_if.sink    cfg,
    ttcb_in_if.sink     req,
    ttcb_out_if.source  rsp
);

    cfg_t       cfg_val;
    ram_req_t   ram_req;
    logic [7:0] rd_data;

    ttcb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    ttcb_cell_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    ttcb_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .cfg     (cfg_val),
        .ram     (ram_req),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

### rtl/ttcb_cfg.sv
// ----------------------------------------------------------------------------
// ttcb_cfg: configuration registers
// Holds the column and row counts and clamps them to the usable range.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_cfg
    import ttcb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ttcb_cfg_if.sink    cfg,
    output cfg_t        cfg_out
);

    logic [7:0] cols_reg;
    logic [6:0] rows_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_COLS)
                cols_reg <= cfg.data;
            else if (cfg.index == REG_ROWS)
                rows_reg <= cfg.data[6:0];
        end
    end

    always_comb
    begin
        priority if (cols_reg == 8'd0)
            cfg_out.act_cols = 8'd1;
        else if (cols_reg > COLS_MAX)
            cfg_out.act_cols = COLS_MAX;
        else
            cfg_out.act_cols = cols_reg;

        priority if (rows_reg == 7'd0)
            cfg_out.act_rows = 7'd1;
        else if (rows_reg > ROWS_MAX)
            cfg_out.act_rows = ROWS_MAX;
        else
            cfg_out.act_rows = rows_reg;
    end

endmodule

`default_nettype wire

### rtl/ttcb_cell_ram.sv
// ----------------------------------------------------------------------------
// ttcb_cell_ram: character cell store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_cell_ram
    import ttcb_pkg::*;
(
    input  wire logic       clk,
    input  ram_req_t        req,
    output logic [7:0]      rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.wr_addr] <= req.wr_data;
        if (req.rd_en)
            rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/ttcb_seq.sv
// ----------------------------------------------------------------------------
// ttcb_seq: cursor and store sequencer
// Clears the store after reset, runs each item, walks the store on scroll.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_seq
    import ttcb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ttcb_in_if.sink     req,
    ttcb_out_if.source  rsp,
    input  cfg_t        cfg,
    output ram_req_t    ram,
    input  wire logic [7:0] rd_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_BLANK,
        ST_DONE
    } state_t;

    state_t           state_reg;
    op_t              op_reg;
    logic [7:0]       ch_reg;
    logic [ROW_W-1:0] rr_reg;
    logic [COL_W-1:0] rc_reg;
    logic [7:0]       cols_reg;
    logic [6:0]       rows_reg;
    logic [COL_W-1:0] cur_col_reg;
    logic [ROW_W-1:0] cur_row_reg;
    logic [COL_W-1:0] scr_col_reg;
    logic [ROW_W-1:0] scr_row_reg;
    logic             scroll_reg;
    logic             hit_reg;

    logic             out_valid_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic             out_scr_reg;
    logic [7:0]       out_cell_reg;

    logic [7:0]       col8;
    logic [6:0]       line7;
    logic             in_area;
    logic             do_write;
    logic [7:0]       col_a;
    logic [6:0]       line_a;
    logic [7:0]       col_b;
    logic [6:0]       line_b;
    logic             scroll_now;
    logic             read_hit;
    logic [ROW_W-1:0] last_row;
    logic             col_last;
    logic             out_free;

    // cursor step for one key or raw item
    always_comb
    begin
        col8     = {1'b0, cur_col_reg};
        line7    = {1'b0, cur_row_reg};
        in_area  = (col8 < cols_reg) && (line7 < rows_reg);
        do_write = 1'b0;
        col_a    = col8;
        line_a   = line7;
        if (ch_reg == CH_NEWLINE)
        begin
            col_a  = 8'd0;
            line_a = line7 + 7'd1;
        end
        else if (op_reg == OP_RAW)
        begin
            if (in_area)
            begin
                do_write = 1'b1;
                col_a    = col8 + 8'd1;
            end
        end
        else if (ch_reg == CH_BACKSPACE)
        begin
            if (col8 != 8'd0)
                col_a = col8 - 8'd1;
        end
        else if (ch_reg >= CH_SPACE && ch_reg <= CH_LAST_PRT)
        begin
            if (in_area)
            begin
                do_write = 1'b1;
                col_a    = col8 + 8'd1;
            end
        end
        if (col_a >= cols_reg)
        begin
            col_b  = 8'd0;
            line_b = line_a + 7'd1;
        end
        else
        begin
            col_b  = col_a;
            line_b = line_a;
        end
        scroll_now = (line_b >= rows_reg);
        read_hit   = ({1'b0, rr_reg} < rows_reg) && ({1'b0, rc_reg} < cols_reg);
    end

    assign last_row = ROW_W'(rows_reg - 7'd1);
    assign col_last = ({1'b0, scr_col_reg} == (cols_reg - 8'd1));
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        ram = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram.wr_en   = 1'b1;
                ram.wr_addr = {scr_row_reg, scr_col_reg};
                ram.wr_data = CH_SPACE;
            end
            ST_EXEC:
            begin
                ram.wr_en   = (op_reg == OP_KEY || op_reg == OP_RAW) && do_write;
                ram.wr_addr = {cur_row_reg, cur_col_reg};
                ram.wr_data = ch_reg;
                ram.rd_en   = (op_reg == OP_READ) && read_hit;
                ram.rd_addr = {rr_reg, rc_reg};
            end
            ST_SCR_RD:
            begin
                ram.rd_en   = 1'b1;
                ram.rd_addr = {scr_row_reg + ROW_W'(1), scr_col_reg};
            end
            ST_SCR_WR:
            begin
                ram.wr_en   = 1'b1;
                ram.wr_addr = {scr_row_reg, scr_col_reg};
                ram.wr_data = rd_data;
            end
            ST_BLANK:
            begin
                ram.wr_en   = 1'b1;
                ram.wr_addr = {last_row, scr_col_reg};
                ram.wr_data = CH_SPACE;
            end
            default:
            begin
                ram = '0;
            end
        endcase
    end

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.cursor_col = out_col_reg;
    assign rsp.cursor_row = out_row_reg;
    assign rsp.scrolled   = out_scr_reg;
    assign rsp.cell_char  = out_cell_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            scr_col_reg   <= '0;
            scr_row_reg   <= '0;
            scroll_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_NOP;
            cols_reg      <= COLS_RESET;
            rows_reg      <= ROWS_RESET;
        end
        else
        begin
            if (rsp.ready && state_reg != ST_DONE)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    {scr_row_reg, scr_col_reg} <= {scr_row_reg, scr_col_reg} + ADDR_W'(1);
                    if (&{scr_row_reg, scr_col_reg})
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg    <= op_t'(req.opcode);
                        ch_reg    <= req.char_code;
                        rr_reg    <= req.read_row;
                        rc_reg    <= req.read_col;
                        cols_reg  <= cfg.act_cols;
                        rows_reg  <= cfg.act_rows;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    hit_reg     <= read_hit;
                    scr_col_reg <= '0;
                    scr_row_reg <= '0;
                    if ((op_reg == OP_KEY || op_reg == OP_RAW) && scroll_now)
                    begin
                        cur_col_reg <= COL_W'(col_b);
                        cur_row_reg <= last_row;
                        scroll_reg  <= 1'b1;
                        state_reg   <= (rows_reg == 7'd1) ? ST_BLANK : ST_SCR_RD;
                    end
                    else
                    begin
                        scroll_reg <= 1'b0;
                        state_reg  <= ST_DONE;
                        if (op_reg == OP_KEY || op_reg == OP_RAW)
                        begin
                            cur_col_reg <= COL_W'(col_b);
                            cur_row_reg <= ROW_W'(line_b);
                        end
                    end
                end
                ST_SCR_RD:
                begin
                    state_reg <= ST_SCR_WR;
                end
                ST_SCR_WR:
                begin
                    if (col_last)
                    begin
                        scr_col_reg <= '0;
                        if ({1'b0, scr_row_reg} + 7'd2 == rows_reg)
                        begin
                            state_reg <= ST_BLANK;
                        end
                        else
                        begin
                            scr_row_reg <= scr_row_reg + ROW_W'(1);
                            state_reg   <= ST_SCR_RD;
                        end
                    end
                    else
                    begin
                        scr_col_reg <= scr_col_reg + COL_W'(1);
                        state_reg   <= ST_SCR_RD;
                    end
                end
                ST_BLANK:
                begin
                    if (col_last)
                        state_reg <= ST_DONE;
                    else
                        scr_col_reg <= scr_col_reg + COL_W'(1);
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_col_reg   <= cur_col_reg;
                        out_row_reg   <= cur_row_reg;
                        out_scr_reg   <= scroll_reg;
                        out_cell_reg  <= (op_reg == OP_READ && hit_reg) ? rd_data : 8'd0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_cursor_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (op_reg == OP_KEY || op_reg == OP_RAW))
        |-> ({1'b0, cur_col_reg} < cols_reg && {1'b0, cur_row_reg} < rows_reg))
        else $error("cursor outside active area after write item");

    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && scroll_reg) |-> (cur_row_reg == last_row))
        else $error("scroll left cursor off last row");

    a_copy_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCR_WR) |-> ({1'b0, scr_row_reg} + 7'd1 < rows_reg))
        else $error("scroll copy past second to last row");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> !ram.wr_en)
        else $error("store written while not working on an item");

    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not posted on completion");

endmodule

`default_nettype wire

### tb/ttcb_screen_check.sv
// ----------------------------------------------------------------------------
// ttcb_screen_check: result checker for the text terminal char buffer
// Watches the config, item and result channels. It keeps its own copy of
// the cell grid, the cursor and the area size, predicts one result per
// accepted item and compares each delivered result, field by field, with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module ttcb_screen_check
    import ttcb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ttcb_cfg_if  cfg,
    ttcb_in_if   req,
    ttcb_out_if  rsp,
    output int   fail_count,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             scrolled;
        logic [7:0]       chr;
    } cursor_report_t;

    logic [7:0]     screen [DEPTH];
    int unsigned    col_pos;
    int unsigned    row_pos;
    logic [7:0]     cols_reg;
    logic [6:0]     rows_reg;
    cursor_report_t expected_q [$];
    int             fails;

    assign fail_count = fails;

    // zero acts as one, anything above the limit acts as the limit
    function automatic int unsigned span(int unsigned v, int unsigned lim);
        if (v == 0)
        begin
            return 1;
        end
        return (v > lim) ? lim : v;
    endfunction

    function automatic void place_char(logic [7:0] ch, int unsigned cols,
                                       int unsigned rows);
        if (col_pos < cols && row_pos < rows)
        begin
            screen[row_pos * MAX_COLS + col_pos] = ch;
            col_pos++;
        end
    endfunction

    function automatic cursor_report_t predict_cursor_report(op_t op, logic [7:0] ch,
                                                             logic [5:0] rr,
                                                             logic [6:0] rc);
        int unsigned    cols;
        int unsigned    rows;
        int unsigned    r;
        int unsigned    c;
        cursor_report_t rep;
        cols = span(cols_reg, MAX_COLS);
        rows = span(rows_reg, MAX_ROWS);
        rep  = '0;
        if (op == OP_KEY || op == OP_RAW)
        begin
            if (ch == CH_NEWLINE)
            begin
                col_pos = 0;
                row_pos++;
            end
            else if (op == OP_RAW)
            begin
                place_char(ch, cols, rows);
            end
            else if (ch == CH_BACKSPACE)
            begin
                if (col_pos > 0)
                begin
                    col_pos--;
                end
            end
            else if (ch >= CH_SPACE && ch <= CH_LAST_PRT)
            begin
                place_char(ch, cols, rows);
            end
            if (col_pos >= cols)
            begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= rows)
            begin
                for (r = 0; r + 1 < rows; r++)
                begin
                    for (c = 0; c < cols; c++)
                    begin
                        screen[r * MAX_COLS + c] = screen[(r + 1) * MAX_COLS + c];
                    end
                end
                for (c = 0; c < cols; c++)
                begin
                    screen[(rows - 1) * MAX_COLS + c] = CH_SPACE;
                end
                row_pos      = rows - 1;
                rep.scrolled = 1'b1;
            end
        end
        else if (op == OP_READ && rr < rows && rc < cols)
        begin
            rep.chr = screen[rr * MAX_COLS + rc];
        end
        rep.col = col_pos[COL_W-1:0];
        rep.row = row_pos[ROW_W-1:0];
        return rep;
    endfunction

    task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        int             idx;
        cursor_report_t got;
        cursor_report_t want;
        if (!rst_n)
        begin
            for (idx = 0; idx < DEPTH; idx++)
            begin
                screen[idx] = CH_SPACE;
            end
            col_pos  = 0;
            row_pos  = 0;
            cols_reg = COLS_RESET;
            rows_reg = ROWS_RESET;
            expected_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.col      = rsp.cursor_col;
                got.row      = rsp.cursor_row;
                got.scrolled = rsp.scrolled;
                got.chr      = rsp.cell_char;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual col %0d row %0d",
                             $time, got.col, got.row);
                    fails++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("cursor_col", 8'(want.col), 8'(got.col));
                    check_field("cursor_row", 8'(want.row), 8'(got.row));
                    check_field("scrolled", 8'(want.scrolled), 8'(got.scrolled));
                    check_field("cell_char", want.chr, got.chr);
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_COLS: cols_reg = cfg.data;
                    REG_ROWS: rows_reg = cfg.data[6:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                expected_q.push_back(predict_cursor_report(op_t'(req.opcode), req.char_code,
                                                           req.read_row, req.read_col));
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for text_terminal_char_buffer_unit
// Drives a directed burst of keys, raw bytes and reads, then random traffic
// over a series of area sizes (zero, minimum, small, medium, full and out of
// range), with random gaps and stalls on both channels. Results are checked
// by ttcb_screen_check.
// ----------------------------------------------------------------------------
module tb_top;
    import ttcb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_ITEMS = 1800;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    bit   in_steady;
    bit   out_steady;
    int   area_cols = 80;
    int   area_rows = 25;

    ttcb_cfg_if cfg_ch ();
    ttcb_in_if  in_ch ();
    ttcb_out_if out_ch ();

    text_terminal_char_buffer_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (in_ch),
        .rsp   (out_ch)
    );

    ttcb_screen_check CHK (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .req         (in_ch),
        .rsp         (out_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned draw_wait(bit steady);
        return steady ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic send_item(op_t op, logic [7:0] ch, logic [5:0] rr, logic [6:0] rc);
        int unsigned gap;
        gap = draw_wait(in_steady);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.char_code <= ch;
        in_ch.read_row  <= rr;
        in_ch.read_col  <= rc;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic set_config(logic [7:0] cols, logic [6:0] rows);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_COLS;
        cfg_ch.data  <= cols;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.index <= REG_ROWS;
        cfg_ch.data  <= {1'b0, rows};
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        area_cols  = (cols == 0) ? 1 : ((cols > COLS_MAX) ? MAX_COLS : int'(cols));
        area_rows  = (rows == 0) ? 1 : ((rows > ROWS_MAX) ? MAX_ROWS : int'(rows));
        in_steady  = ($urandom_range(0, 3) == 0);
        out_steady = ($urandom_range(0, 3) == 0);
    endtask

    function automatic void rand_item(input bit allow_nl, output op_t op,
                                      output logic [7:0] ch, output logic [5:0] rr,
                                      output logic [6:0] rc);
        int unsigned pick;
        pick = $urandom_range(0, 19);
        op = (pick < 2) ? OP_NOP : (pick < 11) ? OP_KEY : (pick < 16) ? OP_RAW : OP_READ;
        ch = 8'($urandom_range(0, 255));
        rr = 6'($urandom_range(0, 63));
        rc = 7'($urandom_range(0, 127));
        if (op == OP_KEY)
        begin
            case ($urandom_range(0, 9))
                0: ch = CH_NEWLINE;
                1: ch = CH_BACKSPACE;
                2: ;
                default: ch = 8'($urandom_range(CH_SPACE, CH_LAST_PRT));
            endcase
        end
        if (op == OP_READ && $urandom_range(0, 3) != 0)
        begin
            rr = 6'($urandom_range(0, area_rows - 1));
            rc = 7'($urandom_range(0, area_cols - 1));
        end
        if (!allow_nl && ch == CH_NEWLINE)
        begin
            ch = CH_SPACE;
        end
    endfunction

    initial
    begin
        int unsigned stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait(out_steady);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    initial
    begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int          sent;
        int          phase;
        int unsigned phase_len;
        op_t         op;
        logic [7:0]  ch;
        logic [5:0]  rr;
        logic [6:0]  rc;
        logic [7:0]  c_val;
        logic [6:0]  r_val;

        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.opcode    = OP_NOP;
        in_ch.char_code = '0;
        in_ch.read_row  = '0;
        in_ch.read_col  = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_COLS;
        cfg_ch.data     = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset size of 80 x 25
        send_item(OP_KEY,  8'h41,        6'd0,  7'd0);
        send_item(OP_KEY,  CH_SPACE,     6'd63, 7'd127);
        send_item(OP_KEY,  CH_LAST_PRT,  6'd0,  7'd0);
        send_item(OP_KEY,  8'd127,       6'd0,  7'd0);
        send_item(OP_KEY,  8'd31,        6'd0,  7'd0);
        send_item(OP_KEY,  8'd0,         6'd0,  7'd0);
        send_item(OP_KEY,  8'hFF,        6'd0,  7'd0);
        send_item(OP_KEY,  CH_BACKSPACE, 6'd0,  7'd0);
        send_item(OP_RAW,  8'd0,         6'd0,  7'd0);
        send_item(OP_RAW,  8'hFF,        6'd0,  7'd0);
        send_item(OP_RAW,  CH_BACKSPACE, 6'd0,  7'd0);
        send_item(OP_RAW,  CH_NEWLINE,   6'd0,  7'd0);
        send_item(OP_KEY,  CH_BACKSPACE, 6'd0,  7'd0);
        send_item(OP_KEY,  CH_NEWLINE,   6'd0,  7'd0);
        send_item(OP_NOP,  CH_NEWLINE,   6'd63, 7'd127);
        send_item(OP_READ, 8'd0,         6'd0,  7'd0);
        send_item(OP_READ, 8'd0,         6'd0,  7'd2);
        send_item(OP_READ, 8'd0,         6'd0,  7'd3);
        send_item(OP_READ, 8'd0,         6'd24, 7'd79);
        send_item(OP_READ, 8'd0,         6'd25, 7'd0);
        send_item(OP_READ, 8'd0,         6'd0,  7'd80);
        send_item(OP_READ, 8'hFF,        6'd63, 7'd127);
        send_item(OP_READ, 8'd0,         6'd0,  7'd4);

        sent  = 0;
        phase = 0;
        while (sent < TARGET_ITEMS)
        begin
            if (phase == 2)
            begin
                // home the cursor row, then fill the full area with one scroll
                set_config(8'd8, 7'd1);
                send_item(OP_KEY, CH_NEWLINE, 6'd0, 7'd0);
                set_config(COLS_MAX, ROWS_MAX);
                repeat (MAX_ROWS)
                begin
                    send_item($urandom_range(0, 1) ? OP_KEY : OP_RAW, CH_NEWLINE,
                              6'($urandom_range(0, 63)), 7'($urandom_range(0, 127)));
                end
                repeat (90)
                begin
                    rand_item(1'b0, op, ch, rr, rc);
                    send_item(op, ch, rr, rc);
                end
                set_config(8'hFF, 7'h7F);
                repeat (30)
                begin
                    rand_item(1'b0, op, ch, rr, rc);
                    send_item(op, ch, rr, rc);
                end
                sent += 1 + MAX_ROWS + 120;
            end
            else
            begin
                if (phase == 0)
                begin
                    c_val = 8'd0;
                    r_val = 7'd0;
                end
                else if (phase == 1)
                begin
                    c_val = 8'd1;
                    r_val = 7'd1;
                end
                else
                begin
                    case ($urandom_range(0, 9))
                        0:
                        begin
                            c_val = 8'($urandom_range(129, 255));
                            r_val = 7'($urandom_range(1, 3));
                        end
                        1:
                        begin
                            c_val = 8'($urandom_range(1, 3));
                            r_val = 7'($urandom_range(65, 127));
                        end
                        2:
                        begin
                            c_val = 8'($urandom_range(13, 40));
                            r_val = 7'($urandom_range(9, 16));
                        end
                        3:
                        begin
                            c_val = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 6));
                            r_val = (c_val == 0) ? 7'($urandom_range(0, 6)) : 7'd0;
                        end
                        default:
                        begin
                            c_val = 8'($urandom_range(1, 12));
                            r_val = 7'($urandom_range(1, 8));
                        end
                    endcase
                end
                set_config(c_val, r_val);
                phase_len = $urandom_range(20, 90);
                repeat (phase_len)
                begin
                    rand_item(1'b1, op, ch, rr, rc);
                    if ($urandom_range(0, 39) == 0)
                    begin
                        wait_idle();
                    end
                    send_item(op, ch, rr, rc);
                end
                sent += phase_len;
            end
            phase++;
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
